FILE: rtl/core/sre_pkg.sv
// Shared constants, types and the reciprocal table of the radix digit emitter.
package sre_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int MAX_BASE   = 16;

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int BUF_AW = $clog2(MAX_DIGITS);
  localparam int DIG_W  = $clog2(MAX_BASE);
  localparam int BASE_W = 5;
  localparam int CHAR_W = 8;
  localparam int DATA_W = 64;
  localparam int IDX_W  = 2;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  localparam logic [IDX_W-1:0] REG_BASE_SIZE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_DIGITS_LOW  = 2'd1;
  localparam logic [IDX_W-1:0] REG_DIGITS_HIGH = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic emit_sign;
    logic emit_digit;
  } sre_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic alpha_ok;
    logic neg;
    logic more;
    logic last_digit;
  } sre_status_t;

  // floor(2^32 / n); the quotient estimate is at most one short
  function automatic logic [31:0] recip(input logic [BASE_W-1:0] n);
    logic [31:0] r;
    case (n)
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd14:   r = 32'h1249_2492;
      5'd15:   r = 32'h1111_1111;
      5'd16:   r = 32'h1000_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/sre_ctrl.sv
// Sequencing state machine of the radix digit emitter.
module sre_ctrl import sre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  sre_status_t status,
  output sre_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_MUL   = 6'b000100,
    S_CORR  = 6'b001000,
    S_SIGN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = status.alpha_ok ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        state_next = S_CORR;
      end
      S_CORR: begin
        if (status.more) state_next = S_MUL;
        else if (status.neg) state_next = S_SIGN;
        else state_next = S_EMIT;
      end
      S_SIGN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.last_digit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy           = (state != S_IDLE);
  assign cmd.load       = (state == S_IDLE) && start;
  assign cmd.mul        = (state == S_MUL);
  assign cmd.step       = (state == S_CORR);
  assign cmd.emit_sign  = (state == S_SIGN);
  assign cmd.emit_digit = (state == S_EMIT);

endmodule

FILE: rtl/core/sre_dp.sv
// Datapath: alphabet registers and check, reciprocal divider, digit buffer, output.
module sre_dp import sre_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_index,
  input  logic [DATA_W-1:0]  wr_data,
  input  logic signed [31:0] value,
  input  sre_cmd_t           cmd,
  output sre_status_t        status,
  output logic               strobe,
  output logic [CHAR_W-1:0]  out_char,
  output logic               last
);

  logic [BASE_W-1:0] base_size;
  logic [DATA_W-1:0] digits_low;
  logic [DATA_W-1:0] digits_high;

  logic [31:0]       mag;
  logic              neg;
  logic [63:0]       prod;
  logic [CNT_W-1:0]  cnt;
  logic [DIG_W-1:0]  dig_buf [MAX_DIGITS];

  logic [CHAR_W-1:0] alpha [MAX_BASE];
  logic              bad;

  logic [31:0]       q_est;
  logic [31:0]       r_full;
  logic [5:0]        r_small;
  logic              corr;
  logic [DIG_W-1:0]  digit;
  logic [31:0]       q;
  logic [BUF_AW-1:0] rd_idx;

  // configuration writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      base_size   <= '0;
      digits_low  <= '0;
      digits_high <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BASE_SIZE:   base_size   <= wr_data[BASE_W-1:0];
        REG_DIGITS_LOW:  digits_low  <= wr_data;
        REG_DIGITS_HIGH: digits_high <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_BASE; k++) begin
      if (k < 8) alpha[k] = digits_low[8*k +: CHAR_W];
      else alpha[k] = digits_high[8*(k-8) +: CHAR_W];
    end
  end

  // base size check (2 to MAX_BASE), then no sign characters or repeats among the first base_size characters
  always_comb begin
    bad = (base_size < BASE_W'(2)) || (base_size > BASE_W'(MAX_BASE));
    for (int i = 0; i < MAX_BASE; i++) begin
      if (BASE_W'(i) < base_size) begin
        if (alpha[i] == CH_MINUS || alpha[i] == CH_PLUS) bad = 1'b1;
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if (BASE_W'(j) < base_size && alpha[i] == alpha[j]) bad = 1'b1;
        end
      end
    end
  end

  // quotient estimate and one-step correction
  always_comb begin
    q_est   = prod[63:32];
    r_full  = mag - 32'(q_est * {27'd0, base_size});
    r_small = r_full[5:0];
    corr    = (r_small >= {1'b0, base_size});
    digit   = corr ? DIG_W'(r_small - {1'b0, base_size}) : DIG_W'(r_small);
    q       = corr ? q_est + 32'd1 : q_est;
  end

  assign rd_idx = BUF_AW'(cnt - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[31];
      mag <= value[31] ? 32'(-$unsigned(value)) : $unsigned(value);
      cnt <= '0;
    end
    if (cmd.mul) begin
      prod <= 64'(mag) * 64'(recip(base_size));
    end
    if (cmd.step) begin
      dig_buf[cnt[BUF_AW-1:0]] <= digit;
      mag <= q;
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.emit_sign) begin
      out_char <= CH_MINUS;
      last     <= 1'b0;
    end
    if (cmd.emit_digit) begin
      out_char <= alpha[dig_buf[rd_idx]];
      last     <= (cnt == CNT_W'(1));
      cnt      <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign || cmd.emit_digit;
    end
  end

  assign status.alpha_ok   = !bad;
  assign status.neg        = neg;
  assign status.more       = (q != 32'd0) && (cnt < CNT_W'(MAX_DIGITS - 1));
  assign status.last_digit = (cnt == CNT_W'(1));

endmodule

FILE: rtl/core/signed_radix_digit_emitter.sv
// Signed integer to text in a configured radix: top level.
// Per item: the start beat, a check state, a multiply and a correct state
//   per digit, a '-' state when negative, then one char a cycle, each with strobe.
// Busy is high in every state but idle; the next start beat is taken once busy
//   drops.
// An invalid alphabet ends the item in the check state and gives no chars.
// Synchronous active-high reset clears the configuration registers, strobe and the
//   sequencer; the receiver cannot stall, each char is shown for one cycle only.
module signed_radix_digit_emitter import sre_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] value,
  // configuration writes
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_index,
  input  logic [DATA_W-1:0]  wr_data,
  // character beats
  output logic               strobe,
  output logic [CHAR_W-1:0]  out_char,
  output logic               last
);

  sre_cmd_t    cmd;
  sre_status_t status;

  // sequencer: check, divide loop, optional sign, emit loop
  sre_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath: digits are found least significant first into a buffer,
  // then read back most significant first
  sre_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .value    (value),
    .cmd      (cmd),
    .status   (status),
    .strobe   (strobe),
    .out_char (out_char),
    .last     (last)
  );

endmodule
